// ----- rtl/tdcq_pkg.sv -----
package tdcq_pkg;

    // fixed widths of coordinates and time
    localparam int COORD_BITS = 12;
    localparam int TIME_BITS  = 32;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // register reset values
    localparam logic [11:0] RST_DRAG_THRESHOLD  = 12'd12;
    localparam logic [15:0] RST_CLICK_GUARD     = 16'd300;
    localparam logic [7:0]  RST_FAILURE_LIMIT   = 8'd8;
    localparam logic [15:0] RST_RECOVERY_IVL    = 16'd1000;
    localparam logic [12:0] RST_SCREEN_WIDTH    = 13'd240;
    localparam logic [12:0] RST_SCREEN_HEIGHT   = 13'd280;

    localparam logic [7:0]  FAIL_SAT = 8'hFF;
    localparam logic [3:0]  NIBBLE_MASK = 4'hF;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DRAG_THRESHOLD = 3'd0,
        REG_CLICK_GUARD    = 3'd1,
        REG_FAILURE_LIMIT  = 3'd2,
        REG_RECOVERY_IVL   = 3'd3,
        REG_SCREEN_WIDTH   = 3'd4,
        REG_SCREEN_HEIGHT  = 3'd5
    } t_reg_idx;

    // item kinds
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_FAIL   = 2'd1,
        OP_PROBE  = 2'd2,
        OP_TICK   = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode                opcode;
        logic [TIME_BITS-1:0]   now_ms;
        logic [7:0]             finger_count;
        logic [7:0]             x_high_byte;
        logic [7:0]             x_low_byte;
        logic [7:0]             y_high_byte;
        logic [7:0]             y_low_byte;
        logic                   probe_ok;
        logic                   probe_is_recovery;
    } t_in_item;

    typedef struct packed {
        logic                   pressed;
        logic [COORD_BITS-1:0]  point_x;
        logic [COORD_BITS-1:0]  point_y;
        logic                   click_allowed;
        logic                   recover_request;
        logic                   controller_healthy;
    } t_out_item;

    typedef struct packed {
        logic [11:0] drag_threshold;
        logic [15:0] click_guard_ms;
        logic [7:0]  failure_limit;
        logic [15:0] recovery_interval_ms;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
    } t_cfg;

    // coordinate from raw high and low bytes
    function automatic logic [COORD_BITS-1:0] unpack(input logic [7:0] hi,
                                                     input logic [7:0] lo);
        logic [11:0] raw;
        raw = {hi[3:0] & NIBBLE_MASK, lo};
        return COORD_BITS'(raw);
    endfunction

endpackage

// ----- rtl/tdcq_cfg.sv -----
module tdcq_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tdcq_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [tdcq_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output tdcq_pkg::t_cfg                      o_cfg
);

    tdcq_pkg::t_cfg r_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register file, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drag_threshold       <= tdcq_pkg::RST_DRAG_THRESHOLD;
            r_cfg.click_guard_ms       <= tdcq_pkg::RST_CLICK_GUARD;
            r_cfg.failure_limit        <= tdcq_pkg::RST_FAILURE_LIMIT;
            r_cfg.recovery_interval_ms <= tdcq_pkg::RST_RECOVERY_IVL;
            r_cfg.screen_width         <= tdcq_pkg::RST_SCREEN_WIDTH;
            r_cfg.screen_height        <= tdcq_pkg::RST_SCREEN_HEIGHT;
        end else if (i_cfg_valid) begin
            case (tdcq_pkg::t_reg_idx'(i_cfg_index))
                tdcq_pkg::REG_DRAG_THRESHOLD: r_cfg.drag_threshold       <= i_cfg_data[11:0];
                tdcq_pkg::REG_CLICK_GUARD:    r_cfg.click_guard_ms       <= i_cfg_data;
                tdcq_pkg::REG_FAILURE_LIMIT:  r_cfg.failure_limit        <= i_cfg_data[7:0];
                tdcq_pkg::REG_RECOVERY_IVL:   r_cfg.recovery_interval_ms <= i_cfg_data;
                tdcq_pkg::REG_SCREEN_WIDTH:   r_cfg.screen_width         <= i_cfg_data[12:0];
                tdcq_pkg::REG_SCREEN_HEIGHT:  r_cfg.screen_height        <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/tdcq_core.sv -----
module tdcq_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tdcq_pkg::t_cfg         i_cfg,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  tdcq_pkg::t_in_item     i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output tdcq_pkg::t_out_item    o_out_data
);

    localparam int CB = tdcq_pkg::COORD_BITS;
    localparam int TB = tdcq_pkg::TIME_BITS;

    // input stage
    logic                r_in_valid;
    tdcq_pkg::t_in_item  r_in;

    // result stage
    logic                r_out_valid;
    tdcq_pkg::t_out_item r_out;
    tdcq_pkg::t_out_item n_out;

    // qualifier state
    logic          r_healthy,  n_healthy;
    logic [7:0]    r_fail_cnt, n_fail_cnt;
    logic          r_pending,  n_pending;
    logic [TB-1:0] r_last_rec, n_last_rec;
    logic          r_touch,    n_touch;
    logic          r_drag,     n_drag;
    logic [CB-1:0] r_org_x,    n_org_x;
    logic [CB-1:0] r_org_y,    n_org_y;
    logic [TB-1:0] r_block,    n_block;

    logic adv;
    logic accept;

    // item moves to the result register when that is free or being emptied
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign accept     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    // state registers, updated as each transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_healthy  <= 1'b0;
            r_fail_cnt <= '0;
            r_pending  <= 1'b0;
            r_last_rec <= '0;
            r_touch    <= 1'b0;
            r_drag     <= 1'b0;
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_block    <= '0;
        end else if (adv) begin
            r_healthy  <= n_healthy;
            r_fail_cnt <= n_fail_cnt;
            r_pending  <= n_pending;
            r_last_rec <= n_last_rec;
            r_touch    <= n_touch;
            r_drag     <= n_drag;
            r_org_x    <= n_org_x;
            r_org_y    <= n_org_y;
            r_block    <= n_block;
        end
    end

    // per item datapath
    logic [CB-1:0] x, y;
    logic [CB-1:0] dx, dy;
    logic          on_screen;
    logic          press, release_req;
    logic          blk_set;
    logic [7:0]    fail_inc;
    logic [TB-1:0] since_block;
    logic [TB-1:0] since_rec;

    assign x  = tdcq_pkg::unpack(r_in.x_high_byte, r_in.x_low_byte);
    assign y  = tdcq_pkg::unpack(r_in.y_high_byte, r_in.y_low_byte);
    assign dx = (x > r_org_x) ? x - r_org_x : r_org_x - x;
    assign dy = (y > r_org_y) ? y - r_org_y : r_org_y - y;
    assign on_screen = (r_in.finger_count != 8'd0)
                 && ({1'b0, x} < i_cfg.screen_width)
                 && ({1'b0, y} < i_cfg.screen_height);
    assign fail_inc    = (r_fail_cnt != tdcq_pkg::FAIL_SAT) ? r_fail_cnt + 8'd1 : r_fail_cnt;
    assign since_block = r_in.now_ms - r_block;
    assign since_rec   = r_in.now_ms - r_last_rec;

    always_comb begin
        n_healthy   = r_healthy;
        n_fail_cnt  = r_fail_cnt;
        n_pending   = r_pending;
        n_last_rec  = r_last_rec;
        n_touch     = r_touch;
        n_drag      = r_drag;
        n_org_x     = r_org_x;
        n_org_y     = r_org_y;
        n_block     = r_block;
        press       = 1'b0;
        release_req = 1'b0;
        blk_set     = 1'b0;
        n_out       = '0;

        // item kind
        case (r_in.opcode)
            tdcq_pkg::OP_SAMPLE: begin
                if (r_healthy) begin
                    n_fail_cnt = '0;
                    if (on_screen) begin
                        press = 1'b1;
                    end else begin
                        release_req = 1'b1;
                    end
                end else begin
                    release_req = 1'b1;
                end
            end
            tdcq_pkg::OP_FAIL: begin
                if (r_healthy) begin
                    n_fail_cnt = fail_inc;
                    if (fail_inc >= i_cfg.failure_limit) begin
                        n_healthy = 1'b0;
                        n_pending = 1'b1;
                    end
                end
                release_req = 1'b1;
            end
            tdcq_pkg::OP_PROBE: begin
                n_healthy  = r_in.probe_ok;
                n_fail_cnt = '0;
                n_pending  = r_in.probe_is_recovery && !r_in.probe_ok;
            end
            tdcq_pkg::OP_TICK: begin
                if (r_pending && (since_rec >= {{(TB-16){1'b0}}, i_cfg.recovery_interval_ms}))
                begin
                    n_pending                = 1'b0;
                    n_last_rec               = r_in.now_ms;
                    n_out.recover_request    = 1'b1;
                end
            end
            default: ;
        endcase

        // press: latch origin or look for drag
        if (press) begin
            n_out.pressed = 1'b1;
            n_out.point_x = x;
            n_out.point_y = y;
            if (!r_touch) begin
                n_touch = 1'b1;
                n_drag  = 1'b0;
                n_org_x = x;
                n_org_y = y;
            end else if ((dx >= i_cfg.drag_threshold) || (dy >= i_cfg.drag_threshold)) begin
                n_drag = 1'b1;
            end
        end

        // release: a finished drag starts the click guard
        if (release_req && r_touch) begin
            if (r_drag) begin
                n_block = r_in.now_ms + {{(TB-16){1'b0}}, i_cfg.click_guard_ms};
                blk_set = 1'b1;
            end
            n_touch = 1'b0;
            n_drag  = 1'b0;
        end

        // a fresh guard measured at its own start expires only when zero long
        if (blk_set) begin
            n_out.click_allowed = (i_cfg.click_guard_ms == 16'd0);
        end else begin
            n_out.click_allowed = !n_drag && !since_block[TB-1];
        end
        n_out.controller_healthy = n_healthy;
    end

    // checks
    a_drag_needs_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drag |-> r_touch)
        else $error("drag flag set without touch down");

    a_req_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.opcode != tdcq_pkg::OP_TICK) |=> !r_out.recover_request)
        else $error("recovery request from a non tick item");

    a_press_only_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.opcode != tdcq_pkg::OP_SAMPLE) |=> !r_out.pressed)
        else $error("press reported from a non sample item");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in)))
        else $error("waiting item lost or changed");

endmodule

// ----- rtl/touch_drag_click_qualifier_top.sv -----
// a taken transaction moves from the input register to the result register, where
// it is offered, when that register is free or being emptied; throughput: one
// transaction per cycle unless the output stalls; the input and result registers
// form a two-stage pipeline and all state is updated in the single compute stage
// reset: synchronous, active low; state and control registers return to defaults
// and the controller starts unhealthy with no touch, no pending recovery, no guard
module touch_drag_click_qualifier_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tdcq_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tdcq_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tdcq_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [tdcq_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    tdcq_pkg::t_cfg cfg;

    // configuration registers
    tdcq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // qualifier pipeline
    tdcq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
